FILE: design/assert_macros.svh
// assert_macros.svh: concurrent assertion macros used by cft_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define CFT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/cft_pkg.sv
// cft_pkg: types and constants of the CSV field tokenizer.
// No dependencies; used by all cft modules.
`default_nettype none
package cft_pkg;
   localparam logic [7:0] QUOTE_BYTE   = 8'd34;
   localparam logic [7:0] COMMA_BYTE   = 8'd44;
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_ROW_END   = 2'd2;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
   } token_type;

   // up to three tokens per item, cnt = number used (1..3)
   typedef struct packed {
      token_type [2:0] tok;
      logic [1:0]      cnt;
   } entry_type;
endpackage
`default_nettype wire

FILE: design/cft_front.sv
// cft_front: accepts bytes, tracks quote/row flags, builds token groups.
// Depends on cft_pkg.
`default_nettype none
module cft_front import cft_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_data,
   input  wire logic       accept,
   output entry_type       entry,
   output logic            push
);
   logic preserve_ff, preserve_in;
   logic in_quotes_ff, in_quotes_in;
   logic pending_ff, pending_in;
   logic row_open_ff, row_open_in;

   token_type  plain_tok;
   logic       plain_quote;
   logic       plain_row;
   token_type [2:0] tok;
   logic [1:0] n;
   logic       nq, np, nr;

   always_comb begin
      plain_quote = 1'b0;
      plain_row   = 1'b1;
      if (data_byte == QUOTE_BYTE) begin
         plain_tok   = '{kind: KIND_CHAR, ch: data_byte};
         plain_quote = 1'b1;
      end else if (data_byte == COMMA_BYTE) begin
         plain_tok = '{kind: KIND_FIELD_END, ch: 8'd0};
      end else if (data_byte == NEWLINE_BYTE) begin
         plain_tok = '{kind: KIND_ROW_END, ch: 8'd0};
         plain_row = 1'b0;
      end else begin
         plain_tok = '{kind: KIND_CHAR, ch: data_byte};
      end
   end

   always_comb begin
      tok = '0;
      n   = 2'd0;
      nq  = in_quotes_ff;
      np  = pending_ff;
      nr  = row_open_ff;
      if (pending_ff) begin
         np     = 1'b0;
         tok[n] = '{kind: KIND_CHAR, ch: QUOTE_BYTE};
         n      = n + 2'd1;
         if (data_byte == QUOTE_BYTE) begin
            if (preserve_ff) begin
               tok[n] = '{kind: KIND_CHAR, ch: QUOTE_BYTE};
               n      = n + 2'd1;
            end
            nr = 1'b1;
         end else begin
            tok[n] = plain_tok;
            n      = n + 2'd1;
            nq     = plain_quote;
            nr     = plain_row;
         end
      end else if (in_quotes_ff) begin
         if (data_byte == QUOTE_BYTE) begin
            if (end_of_data) begin
               tok[n] = '{kind: KIND_CHAR, ch: QUOTE_BYTE};
               n      = n + 2'd1;
               nq     = 1'b0;
               nr     = 1'b1;
            end else begin
               np = 1'b1;
            end
         end else begin
            tok[n] = '{kind: KIND_CHAR, ch: data_byte};
            n      = n + 2'd1;
            nr     = 1'b1;
         end
      end else begin
         tok[n] = plain_tok;
         n      = n + 2'd1;
         nq     = plain_quote;
         nr     = plain_row;
      end
      if (end_of_data) begin
         if (nr) begin
            tok[n] = '{kind: KIND_ROW_END, ch: 8'd0};
            n      = n + 2'd1;
         end
         nq = 1'b0;
         np = 1'b0;
         nr = 1'b0;
      end
   end

   assign entry = '{tok: tok, cnt: n};
   assign push  = accept && (n != 2'd0);

   always_comb begin
      preserve_in  = csr_we ? csr_wdata : preserve_ff;
      in_quotes_in = accept ? nq : in_quotes_ff;
      pending_in   = accept ? np : pending_ff;
      row_open_in  = accept ? nr : row_open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preserve_ff  <= 1'b0;
         in_quotes_ff <= 1'b0;
         pending_ff   <= 1'b0;
         row_open_ff  <= 1'b0;
      end else begin
         preserve_ff  <= preserve_in;
         in_quotes_ff <= in_quotes_in;
         pending_ff   <= pending_in;
         row_open_ff  <= row_open_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/cft_queue.sv
// cft_queue: short FIFO of token groups between front and back.
// Depends on cft_pkg.
`default_nettype none
module cft_queue import cft_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  wr_entry,
   input  wire logic       pop,
   output entry_type       rd_entry,
   output logic            not_empty,
   output logic            full
);
   entry_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_entry  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/cft_back.sv
// cft_back: unpacks queued token groups into single items on the output register.
// Depends on cft_pkg.
`default_nettype none
module cft_back import cft_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire entry_type  head,
   input  wire logic       head_valid,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [1:0]      out_kind,
   output logic [7:0]      out_char,
   output logic            out_last
);
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   token_type  tok_ff, tok_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = head_valid && (!valid_ff || out_ready);
   assign at_end = (idx_ff == head.cnt - 2'd1);
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         tok_in   = head.tok[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = tok_ff.kind;
   assign out_char  = tok_ff.ch;
   assign out_last  = last_ff;
endmodule
`default_nettype wire

FILE: design/csv_field_tokenizer_top.sv
// csv_field_tokenizer_top: CSV byte stream to field/row tokens.
// Depends on cft_pkg, cft_front, cft_queue, cft_back.
// An accepted byte passes through the queue and then the output register to reach rsp_.
// Throughput: one byte per cycle while the queue is not full; a byte giving
// k results (k <= 3) fills the output register k times, and the 4-entry queue absorbs the difference.
// Reset clears the quote/row flags, the queue, the output and preserve mode.
`default_nettype none
module csv_field_tokenizer_top import cft_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,   // preserve_doubled_quotes
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_data
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] char_value
   output logic [1:0]      rsp_tuser,   // [1:0] token_kind
   output logic            rsp_tlast    // last_of_run
);
   entry_type wr_entry, head;
   logic      push, pop, head_valid, full, accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   cft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .accept      (accept),
      .entry       (wr_entry),
      .push        (push)
   );

   cft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_entry  (wr_entry),
      .pop       (pop),
      .rd_entry  (head),
      .not_empty (head_valid),
      .full      (full)
   );

   cft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_char   (rsp_tdata),
      .out_last   (rsp_tlast)
   );
endmodule
`default_nettype wire

FILE: design/cft_checker.sv
// cft_checker: port-level assertions for csv_field_tokenizer_top, bound below.
// Depends on cft_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cft_checker import cft_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       csr_we,
   input wire logic       csr_wdata,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);
   `CFT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp item dropped")
   `CFT_ASSERT(a_kind_legal, clock, reset, rsp_tvalid |-> rsp_tuser != 2'd3, "bad token kind")
   `CFT_ASSERT(a_mark_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_CHAR |-> rsp_tdata == 8'd0, "mark carries data")
   `CFT_ASSERT(a_row_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_ROW_END |-> rsp_tlast, "row end not last")
   `CFT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
endmodule

bind csv_field_tokenizer_top cft_checker u_cft_checker (.*);
`default_nettype wire
